FILE: hw/rtl/cnhs_pkg.sv
// ----------------------------------------------------------------------------
// cnhs_pkg: shared types for the colored noise Heun step block
// Operation codes of the shared arithmetic unit, result outcome codes,
// configuration register indexes and the divider status bundle.
// ----------------------------------------------------------------------------
package cnhs_pkg;

    typedef enum logic [0:0] {
        ALU_MUL = 1'b0,
        ALU_ADD = 1'b1
    } alu_op_t;

    typedef enum logic [1:0] {
        OUTC_FIRST = 2'd0,
        OUTC_RETRY = 2'd1,
        OUTC_HARD  = 2'd2
    } outcome_t;

    typedef enum logic [0:0] {
        OPC_ATTEMPT = 1'b0,
        OPC_LOAD    = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_STEP_SIZE  = 3'd0,
        CFG_SQRT_STEP  = 3'd1,
        CFG_INV_TAU    = 3'd2,
        CFG_SHAPE_COEF = 3'd3,
        CFG_BOUND      = 3'd4,
        CFG_BOUNDED    = 3'd5,
        CFG_OU_DECAY   = 3'd6,
        CFG_OU_GAIN    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic done;
        logic ov;
    } div_stat_t;

endpackage

FILE: hw/rtl/cnhs_alu.sv
// ----------------------------------------------------------------------------
// cnhs_alu: shared fixed point multiply and add unit
// Sign-magnitude multiply truncating toward zero, or a plain add, both
// saturating to the data width and flagging saturation.
// ----------------------------------------------------------------------------
module cnhs_alu
    import cnhs_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20
)
(
    input  alu_op_t                       op,
    input  logic signed [DATA_WIDTH-1:0]  a,
    input  logic signed [DATA_WIDTH-1:0]  b,
    output logic signed [DATA_WIDTH-1:0]  res,
    output logic                          ov
);

    localparam int DW = DATA_WIDTH;

    logic [DW-1:0]          ua;
    logic [DW-1:0]          ub;
    logic [2*DW-1:0]        prod;
    logic [2*DW-1:0]        mag;
    logic [2*DW-1:0]        limit;
    logic                   neg;
    logic signed [DW:0]     sum;

    always_comb
    begin
        ua    = a[DW-1] ? DW'(-a) : DW'(a);
        ub    = b[DW-1] ? DW'(-b) : DW'(b);
        prod  = {{DW{1'b0}}, ua} * {{DW{1'b0}}, ub};
        mag   = prod >> FRAC_BITS;
        neg   = a[DW-1] ^ b[DW-1];
        limit = neg ? ((2*DW)'(1) << (DW-1)) : (((2*DW)'(1) << (DW-1)) - (2*DW)'(1));
        sum   = {a[DW-1], a} + {b[DW-1], b};
        res   = '0;
        ov    = 1'b0;
        case (op)
            ALU_MUL:
            begin
                if (mag > limit)
                begin
                    ov  = 1'b1;
                    res = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                end
                else
                begin
                    res = neg ? DW'(-mag[DW-1:0]) : mag[DW-1:0];
                end
            end
            ALU_ADD:
            begin
                if (sum[DW] != sum[DW-1])
                begin
                    ov  = 1'b1;
                    res = sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                end
                else
                begin
                    res = sum[DW-1:0];
                end
            end
            default:
            begin
                res = '0;
                ov  = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cnhs_div.sv
// ----------------------------------------------------------------------------
// cnhs_div: iterative fixed point divider
// Restoring division, one quotient bit per cycle, of the magnitude of the
// numerator scaled by the fraction bits; saturates with the sign applied.
// ----------------------------------------------------------------------------
module cnhs_div
    import cnhs_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [DATA_WIDTH-1:0]  num,
    input  logic signed [DATA_WIDTH-1:0]  den,
    output logic signed [DATA_WIDTH-1:0]  quot,
    output div_stat_t                     stat
);

    localparam int DW = DATA_WIDTH;
    localparam int NB = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              ov_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DW-1:0]     rem_reg;
    logic [NB-1:0]     nsh_reg;
    logic [DW:0]       q_reg;
    logic              big_reg;
    logic              neg_reg;
    logic [DW-1:0]     ud_reg;
    logic signed [DW-1:0] quot_reg;

    logic [DW:0]       rem_sh;
    logic              ge;
    logic [DW:0]       rem_dif;
    logic [DW:0]       limit;
    logic [DW-1:0]     un;
    logic [DW-1:0]     ud;

    always_comb
    begin
        un      = num[DW-1] ? DW'(-num) : DW'(num);
        ud      = den[DW-1] ? DW'(-den) : DW'(den);
        rem_sh  = {rem_reg, nsh_reg[NB-1]};
        ge      = rem_sh >= {1'b0, ud_reg};
        rem_dif = rem_sh - {1'b0, ud_reg};
        limit   = neg_reg ? ((DW+1)'(1) << (DW-1)) : (((DW+1)'(1) << (DW-1)) - (DW+1)'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ov_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    done_reg <= 1'b1;
                    ov_reg   <= 1'b1;
                    quot_reg <= num[DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    rem_reg  <= '0;
                    nsh_reg  <= {un, {FRAC_BITS{1'b0}}};
                    q_reg    <= '0;
                    big_reg  <= 1'b0;
                    neg_reg  <= num[DW-1] ^ den[DW-1];
                    ud_reg   <= ud;
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(NB))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (big_reg || (q_reg > limit))
                    begin
                        ov_reg   <= 1'b1;
                        quot_reg <= neg_reg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                    end
                    else
                    begin
                        ov_reg   <= 1'b0;
                        quot_reg <= neg_reg ? DW'(-q_reg[DW-1:0]) : q_reg[DW-1:0];
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    rem_reg <= ge ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
                    nsh_reg <= {nsh_reg[NB-2:0], 1'b0};
                    q_reg   <= {q_reg[DW-1:0], ge};
                    big_reg <= big_reg | q_reg[DW];
                end
            end
        end
    end

    assign quot      = quot_reg;
    assign stat.done = done_reg;
    assign stat.ov   = ov_reg;

endmodule

FILE: hw/rtl/colored_noise_heun_step.sv
// ----------------------------------------------------------------------------
// colored_noise_heun_step: colored noise generator, one Heun step per item
// Sequencer around one shared multiply/add unit and an iterative divider.
// ----------------------------------------------------------------------------
// An attempt item spends its time in seventeen passes through the shared
// multiply/add unit plus two drift divisions, each of which produces one
// quotient bit per cycle in the divider. A failed attempt gives no result.
// A failed attempt in the fallback range goes on to the Ornstein-Uhlenbeck
// step, the final failure to the hard reset, which gives a result. The block
// takes no new item while an item is in work; a result waits in the output
// register and the next item may be taken as soon as the result has been
// moved into it.
module colored_noise_heun_step
    import cnhs_pkg::*;
#(
    parameter int DATA_WIDTH  = 32,
    parameter int FRAC_BITS   = 20,
    parameter int RETRY_LIMIT = 20
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    // Input item channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic signed [31:0]            load_value,
    input  logic signed [31:0]            gauss_heun,
    input  logic signed [31:0]            gauss_fallback,
    input  logic [19:0]                   uniform_draw,
    // Result item channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_WIDTH-1:0]  noise_value,
    output logic [1:0]                    outcome
);

    localparam int DW = DATA_WIDTH;
    localparam int FW = $clog2(RETRY_LIMIT + 2);
    localparam int USH_L = (FRAC_BITS >= 20) ? FRAC_BITS - 20 : 0;
    localparam int USH_R = (FRAC_BITS >= 20) ? 0 : 20 - FRAC_BITS;
    localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] NINE_TENTHS = (9 * ONE_FX + 64'sd5) / 64'sd10;
    localparam logic signed [63:0] ONE_TENTH = (ONE_FX + 64'sd5) / 64'sd10;
    localparam logic signed [63:0] SMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

    // Saturate a wide value to the data word.
    function automatic logic signed [DW-1:0] sat_fn(input logic signed [63:0] v);
        logic signed [DW-1:0] r;
        if (v > SMAX)
            r = SMAX[DW-1:0];
        else if (v < SMIN)
            r = SMIN[DW-1:0];
        else
            r = v[DW-1:0];
        return r;
    endfunction

    typedef enum logic [4:0] {
        S_IDLE, S_NUM, S_SQ, S_SH, S_DEN, S_DIV, S_K, S_A, S_L, S_S1, S_S2,
        S_T0, S_T, S_DIFF, S_CAND, S_DECIDE, S_OU1, S_OU2, S_OU3, S_OU4,
        S_H1, S_H2, S_H3, S_EMIT
    } state_t;

    // Configuration registers, kept at their written widths.
    logic [30:0]          step_reg;
    logic [30:0]          sqrt_reg;
    logic [30:0]          inv_tau_reg;
    logic signed [31:0]   shape_reg;
    logic [30:0]          bound_reg;
    logic                 bounded_reg;
    logic [20:0]          decay_reg;
    logic [30:0]          gain_reg;

    // Sequencer state and data registers.
    state_t               state_reg;
    logic                 pass_reg;
    logic                 ov_reg;
    logic [FW-1:0]        fail_reg;
    logic signed [DW-1:0] w_reg;
    logic signed [DW-1:0] x_reg;
    logic signed [DW-1:0] t_reg;
    logic signed [DW-1:0] num_reg;
    logic signed [DW-1:0] p1_reg;
    logic signed [DW-1:0] l_reg;
    logic signed [DW-1:0] gh_reg;
    logic signed [DW-1:0] gf_reg;
    logic signed [DW-1:0] u_reg;
    logic                 out_valid_reg;
    logic signed [DW-1:0] out_val_reg;
    outcome_t             outcome_reg;
    logic signed [DW-1:0] emit_val_reg;
    outcome_t             emit_outc_reg;

    // Saturated views of the registers.
    logic signed [DW-1:0] step_s, sqrt_s, inv_s, shape_s, bound_s, decay_s, gain_s;
    logic signed [DW-1:0] one_s, nine_s, tenth_s;
    logic signed [DW-1:0] neg_half;
    logic [DW-1:0]        cand_mag;
    logic [63:0]          u_wide;

    alu_op_t              alu_op;
    logic signed [DW-1:0] alu_a;
    logic signed [DW-1:0] alu_b;
    logic signed [DW-1:0] alu_res;
    logic                 alu_ov;

    logic                 div_start;
    logic signed [DW-1:0] div_quot;
    div_stat_t            div_stat;

    logic                 in_accept;
    logic                 out_free;

    always_comb
    begin
        step_s  = sat_fn({33'b0, step_reg});
        sqrt_s  = sat_fn({33'b0, sqrt_reg});
        inv_s   = sat_fn({33'b0, inv_tau_reg});
        shape_s = sat_fn({{32{shape_reg[31]}}, shape_reg});
        bound_s = sat_fn({33'b0, bound_reg});
        decay_s = sat_fn({43'b0, decay_reg});
        gain_s  = sat_fn({33'b0, gain_reg});
        one_s   = sat_fn(ONE_FX);
        nine_s  = sat_fn(NINE_TENTHS);
        tenth_s = sat_fn(ONE_TENTH);
        // Halving truncates toward zero, then the half is negated.
        neg_half = -((t_reg + $signed({{(DW-1){1'b0}}, t_reg[DW-1]})) >>> 1);
        cand_mag = t_reg[DW-1] ? DW'(-t_reg) : DW'(t_reg);
        u_wide   = ({44'b0, uniform_draw} << USH_L) >> USH_R;
    end

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_op = ALU_MUL;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_NUM:  begin alu_a = x_reg;    alu_b = inv_s;   end
            S_SQ:   begin alu_a = x_reg;    alu_b = x_reg;   end
            S_SH:   begin alu_a = t_reg;    alu_b = shape_s; end
            S_DEN:  begin alu_op = ALU_ADD; alu_a = one_s;  alu_b = t_reg; end
            S_K:    begin alu_a = step_s;   alu_b = p1_reg;  end
            S_A:    begin alu_a = sqrt_s;   alu_b = gh_reg;  end
            S_L:    begin alu_a = l_reg;    alu_b = inv_s;   end
            S_S1:   begin alu_op = ALU_ADD; alu_a = w_reg;  alu_b = t_reg; end
            S_S2:   begin alu_op = ALU_ADD; alu_a = x_reg;  alu_b = l_reg; end
            S_T0:   begin alu_op = ALU_ADD; alu_a = p1_reg; alu_b = t_reg; end
            S_T:    begin alu_a = step_s;   alu_b = t_reg;   end
            S_DIFF: begin alu_op = ALU_ADD; alu_a = neg_half; alu_b = l_reg; end
            S_CAND: begin alu_op = ALU_ADD; alu_a = w_reg;  alu_b = t_reg; end
            S_OU1:  begin alu_a = w_reg;    alu_b = decay_s; end
            S_OU2:  begin alu_a = gain_s;   alu_b = gf_reg;  end
            S_OU3:  begin alu_op = ALU_ADD; alu_a = t_reg;  alu_b = x_reg; end
            S_OU4:  begin alu_a = bound_s;  alu_b = t_reg;   end
            S_H1:   begin alu_a = tenth_s;  alu_b = u_reg;   end
            S_H2:   begin alu_op = ALU_ADD; alu_a = nine_s; alu_b = t_reg; end
            S_H3:   begin alu_a = bound_s;  alu_b = t_reg;   end
            default:
            begin
                alu_op = ALU_MUL;
                alu_a  = '0;
                alu_b  = '0;
            end
        endcase
    end

    cnhs_alu #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ov  (alu_ov)
    );

    assign div_start = (state_reg == S_DEN);

    // The denominator is formed by the shared unit in the same cycle.
    cnhs_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (alu_res),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= 31'd10486;
            sqrt_reg    <= 31'd104858;
            inv_tau_reg <= 31'd1048576;
            shape_reg   <= '0;
            bound_reg   <= '0;
            bounded_reg <= 1'b0;
            decay_reg   <= 21'd1038142;
            gain_reg    <= 31'd104336;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STEP_SIZE:  step_reg    <= cfg_data[30:0];
                CFG_SQRT_STEP:  sqrt_reg    <= cfg_data[30:0];
                CFG_INV_TAU:    inv_tau_reg <= cfg_data[30:0];
                CFG_SHAPE_COEF: shape_reg   <= cfg_data;
                CFG_BOUND:      bound_reg   <= cfg_data[30:0];
                CFG_BOUNDED:    bounded_reg <= cfg_data[0];
                CFG_OU_DECAY:   decay_reg   <= cfg_data[20:0];
                CFG_OU_GAIN:    gain_reg    <= cfg_data[30:0];
                default:        bounded_reg <= bounded_reg;
            endcase
        end
    end

    // Sequencer: state, data registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            ov_reg        <= 1'b0;
            fail_reg      <= '0;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The emit step refills the output register itself.
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;
            if ((alu_op == ALU_ADD || alu_op == ALU_MUL) && state_reg != S_IDLE && alu_ov)
                ov_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (opcode_t'(operation) == OPC_LOAD)
                        begin
                            w_reg    <= sat_fn({{32{load_value[31]}}, load_value});
                            fail_reg <= '0;
                        end
                        else
                        begin
                            gh_reg    <= sat_fn({{32{gauss_heun[31]}}, gauss_heun});
                            gf_reg    <= sat_fn({{32{gauss_fallback[31]}}, gauss_fallback});
                            u_reg     <= sat_fn(u_wide);
                            x_reg     <= w_reg;
                            pass_reg  <= 1'b0;
                            ov_reg    <= 1'b0;
                            state_reg <= S_NUM;
                        end
                    end
                end
                S_NUM:  begin num_reg <= alu_res; state_reg <= S_SQ;  end
                S_SQ:   begin t_reg   <= alu_res; state_reg <= S_SH;  end
                S_SH:   begin t_reg   <= alu_res; state_reg <= S_DEN; end
                S_DEN:  state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        if (div_stat.ov)
                            ov_reg <= 1'b1;
                        if (!pass_reg)
                        begin
                            p1_reg    <= div_quot;
                            state_reg <= S_K;
                        end
                        else
                        begin
                            t_reg     <= div_quot;
                            state_reg <= S_T0;
                        end
                    end
                end
                S_K:    begin t_reg <= alu_res; state_reg <= S_A;  end
                S_A:    begin l_reg <= alu_res; state_reg <= S_L;  end
                S_L:    begin l_reg <= alu_res; state_reg <= S_S1; end
                S_S1:   begin x_reg <= alu_res; state_reg <= S_S2; end
                S_S2:
                begin
                    x_reg     <= alu_res;
                    pass_reg  <= 1'b1;
                    state_reg <= S_NUM;
                end
                S_T0:   begin t_reg <= alu_res; state_reg <= S_T;    end
                S_T:    begin t_reg <= alu_res; state_reg <= S_DIFF; end
                S_DIFF: begin t_reg <= alu_res; state_reg <= S_CAND; end
                S_CAND: begin t_reg <= alu_res; state_reg <= S_DECIDE; end
                S_DECIDE:
                begin
                    if (!bounded_reg || (!ov_reg && ({1'b0, cand_mag} <= {1'b0, bound_s})))
                    begin
                        emit_val_reg  <= t_reg;
                        emit_outc_reg <= (fail_reg != '0) ? OUTC_RETRY : OUTC_FIRST;
                        w_reg         <= t_reg;
                        fail_reg      <= '0;
                        state_reg     <= S_EMIT;
                    end
                    else if (fail_reg >= FW'(RETRY_LIMIT))
                    begin
                        fail_reg  <= '0;
                        state_reg <= S_H1;
                    end
                    else
                    begin
                        fail_reg <= fail_reg + FW'(1);
                        if (fail_reg + FW'(1) > FW'(RETRY_LIMIT / 2))
                            state_reg <= S_OU1;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_OU1:  begin t_reg <= alu_res; state_reg <= S_OU2; end
                S_OU2:  begin x_reg <= alu_res; state_reg <= S_OU3; end
                S_OU3:  begin t_reg <= alu_res; state_reg <= S_OU4; end
                S_OU4:  begin w_reg <= alu_res; state_reg <= S_IDLE; end
                S_H1:   begin t_reg <= alu_res; state_reg <= S_H2; end
                S_H2:   begin t_reg <= alu_res; state_reg <= S_H3; end
                S_H3:
                begin
                    // Zero counts as positive for the sign of the level.
                    emit_val_reg  <= w_reg[DW-1] ? DW'(-alu_res) : alu_res;
                    w_reg         <= w_reg[DW-1] ? DW'(-alu_res) : alu_res;
                    emit_outc_reg <= OUTC_HARD;
                    state_reg     <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_val_reg   <= emit_val_reg;
                        outcome_reg   <= emit_outc_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = out_val_reg;
    assign outcome     = outcome_reg;

`ifndef NO_ASSERTIONS
    a_fail_range: assert property (@(posedge clk) disable iff (!rst_n)
        fail_reg <= FW'(RETRY_LIMIT))
        else $error("failure count beyond retry limit");
    a_hard_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && outcome_reg == OUTC_HARD |-> bounded_reg)
        else $error("hard reset result in unbounded mode");
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished while sequencer not waiting");
`endif

endmodule

FILE: dv/tb_colored_noise_heun_step.sv
// ----------------------------------------------------------------------------
// tb_colored_noise_heun_step: self-checking bench for the colored noise block
// A directed table, then randomly configured phases of attempts and loads, are
// sent through the valid/stall input channel. A fixed-point Heun step model in
// the bench predicts results not set in the table; each is compared on arrival.
// ----------------------------------------------------------------------------
module tb_colored_noise_heun_step;
    import cnhs_pkg::*;

    localparam longint ONE_FX = 64'sd1 << 20;
    localparam longint SMAX   = 64'sd2147483647;
    localparam longint SMIN   = -64'sd2147483648;
    localparam longint P9     = (9 * ONE_FX + 5) / 10;
    localparam longint P1     = (ONE_FX + 5) / 10;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    cfg_index_t         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               operation;
    logic signed [31:0] load_value;
    logic signed [31:0] gauss_heun;
    logic signed [31:0] gauss_fallback;
    logic [19:0]        uniform_draw;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] noise_value;
    logic [1:0]         outcome;

    colored_noise_heun_step uut (.*);

    typedef struct {
        logic signed [31:0] value;
        outcome_t           outc;
    } sample_t;

    // One row of the directed table. A row with go_bounded first switches the
    // block to bounded mode with a zero cut value.
    typedef struct {
        bit          go_bounded;
        int          reps;
        opcode_t     op;
        logic [31:0] ld;
        logic [31:0] gh;
        logic [31:0] gf;
        logic [19:0] u;
        bit          typed;
        logic [31:0] exp_value;
        outcome_t    exp_outc;
    } dir_row_t;

    localparam int NDIR = 15;
    dir_row_t dir_rows [NDIR] = '{
        // Zero level and zero draw after reset give zero on the first try.
        '{0, 1, OPC_ATTEMPT, 0, 0, 0, 0, 1, 0, OUTC_FIRST},
        '{0, 1, OPC_LOAD, 32'h7fff_ffff, 0, 0, 0, 0, 0, OUTC_FIRST},
        '{0, 1, OPC_ATTEMPT, 0, 32'h7fff_ffff, 32'h8000_0000, 20'hfffff, 0, 0, OUTC_FIRST},
        '{0, 1, OPC_LOAD, 32'h8000_0000, 0, 0, 0, 0, 0, OUTC_FIRST},
        '{0, 1, OPC_ATTEMPT, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, OUTC_FIRST},
        '{0, 1, OPC_LOAD, 32'h0010_0000, 0, 0, 0, 0, 0, OUTC_FIRST},
        '{0, 1, OPC_ATTEMPT, 0, 32'hffff_ffff, 1, 1, 0, 0, OUTC_FIRST},
        '{0, 1, OPC_LOAD, 0, 0, 0, 0, 0, 0, OUTC_FIRST},
        // Bounded with a zero cut: any nonzero candidate fails, and the hard
        // reset after the last retry lands on zero.
        '{1, 1, OPC_ATTEMPT, 0, 0, 0, 0, 1, 0, OUTC_FIRST},
        '{0, 20, OPC_ATTEMPT, 0, 32'h0010_0000, 32'h0030_0000, 0, 0, 0, OUTC_FIRST},
        '{0, 1, OPC_ATTEMPT, 0, 32'h0010_0000, 0, 20'hfffff, 1, 0, OUTC_HARD},
        // A load in the middle of a retry run clears the failure count.
        '{0, 5, OPC_ATTEMPT, 0, 32'h0010_0000, 32'h8000_0000, 0, 0, 0, OUTC_FIRST},
        '{0, 1, OPC_LOAD, 0, 0, 0, 0, 0, 0, OUTC_FIRST},
        '{0, 1, OPC_ATTEMPT, 0, 0, 0, 0, 1, 0, OUTC_FIRST},
        '{0, 21, OPC_ATTEMPT, 0, 32'h8000_0000, 32'h7fff_ffff, 20'h55555, 0, 0, OUTC_FIRST}
    };

    // Model state and registers.
    longint  m_step, m_sqrt, m_itau, m_shape, m_bound, m_decay, m_gain;
    bit      m_bounded;
    longint  m_level, m_work;
    int      m_fails;
    bit      ovf;

    sample_t pending_q[$];
    int      errors, n_results, n_retry, n_hard, n_items;
    bit      no_gap, no_stall;
    int      stall_left;

    function automatic longint sat(longint v);
        if (v > SMAX) begin ovf = 1; return SMAX; end
        if (v < SMIN) begin ovf = 1; return SMIN; end
        return v;
    endfunction

    function automatic longint with_sign(bit neg, longint unsigned m);
        longint unsigned lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (m > lim) begin ovf = 1; return neg ? SMIN : SMAX; end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint unsigned ua, ub;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        return with_sign((a < 0) != (b < 0), (ua * ub) >> 20);
    endfunction

    function automatic longint fx_div(longint n, longint d);
        longint unsigned un, ud;
        if (d == 0) begin ovf = 1; return n < 0 ? SMIN : SMAX; end
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        return with_sign((n < 0) != (d < 0), (un << 20) / ud);
    endfunction

    function automatic longint drift(longint eta);
        longint num, den;
        num = fx_mul(eta, m_itau);
        den = sat(ONE_FX + fx_mul(fx_mul(eta, eta), m_shape));
        return fx_div(num, den);
    endfunction

    function automatic void apply_cfg(cfg_index_t idx, logic [31:0] v);
        case (idx)
            CFG_STEP_SIZE:  m_step = v[30:0];
            CFG_SQRT_STEP:  m_sqrt = v[30:0];
            CFG_INV_TAU:    m_itau = v[30:0];
            CFG_SHAPE_COEF: m_shape = longint'(signed'(v));
            CFG_BOUND:      m_bound = v[30:0];
            CFG_BOUNDED:    m_bounded = v[0];
            CFG_OU_DECAY:   m_decay = v[20:0];
            default:        m_gain = v[30:0];
        endcase
    endfunction

    // One item through the model. Returns 1 and fills s when a result is due.
    function automatic bit heun_item(opcode_t op, logic [31:0] ld, logic [31:0] gh,
                                     logic [31:0] gf, logic [19:0] u, output sample_t s);
        longint eta, p1, p2, k, l, t, cand, ou, mag;
        s = '{0, OUTC_FIRST};
        if (op == OPC_LOAD) begin
            m_level = longint'(signed'(ld));
            m_work = m_level;
            m_fails = 0;
            return 0;
        end
        ovf = 0;
        eta = m_work;
        p1 = drift(eta);
        k = fx_mul(m_step, p1);
        l = fx_mul(fx_mul(m_sqrt, longint'(signed'(gh))), m_itau);
        p2 = drift(sat(sat(eta + k) + l));
        t = fx_mul(m_step, sat(p1 + p2));
        cand = sat(eta + sat(-(t / 2) + l));
        if (!m_bounded || (!ovf && (cand < 0 ? -cand : cand) <= m_bound)) begin
            s.value = cand[31:0];
            s.outc = m_fails > 0 ? OUTC_RETRY : OUTC_FIRST;
            m_level = cand;
            m_work = cand;
            m_fails = 0;
            return 1;
        end
        m_fails++;
        if (m_fails > 20) begin
            mag = fx_mul(m_bound, sat(P9 + fx_mul(P1, longint'(u))));
            m_level = m_work < 0 ? -mag : mag;
            m_work = m_level;
            m_fails = 0;
            s.value = m_level[31:0];
            s.outc = OUTC_HARD;
            return 1;
        end
        if (m_fails > 10) begin
            ou = sat(fx_mul(m_work, m_decay) + fx_mul(m_gain, longint'(signed'(gf))));
            m_work = fx_mul(m_bound, ou);
        end
        return 0;
    endfunction

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(100_000_000);
        $display("FAILURE");
        $finish;
    end

    // Result side: draws a stall length per result and checks each accepted
    // result against the oldest expectation.
    always @(posedge clk)
    begin
        sample_t e;
        int w;
        if (out_valid && !out_stall) begin
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value=%0d outcome=%0d",
                         $time, noise_value, outcome);
            end else begin
                e = pending_q.pop_front();
                n_results++;
                if (e.outc == OUTC_RETRY) n_retry++;
                if (e.outc == OUTC_HARD) n_hard++;
                if (noise_value !== e.value) begin
                    errors++;
                    $display("%0t: noise_value expected %0d actual %0d",
                             $time, e.value, noise_value);
                end
                if (outcome !== e.outc) begin
                    errors++;
                    $display("%0t: outcome expected %0d actual %0d",
                             $time, e.outc, outcome);
                end
            end
            w = no_stall ? 0 : $urandom_range(0, 16);
            stall_left <= w;
            out_stall <= (w != 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        apply_cfg(idx, v);
    endtask

    // Stop sending, let every expected result arrive, then allow for a
    // resultless attempt that may still be in work.
    task automatic drain();
        in_valid <= 0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Presents one item after a random gap and waits for it to be taken.
    task automatic send(opcode_t op, logic [31:0] ld, logic [31:0] gh, logic [31:0] gf,
                        logic [19:0] u, bit typed, sample_t typed_s);
        int gap;
        sample_t s;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        operation <= op;
        load_value <= ld;
        gauss_heun <= gh;
        gauss_fallback <= gf;
        uniform_draw <= u;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_items++;
        if (heun_item(op, ld, gh, gf, u, s))
            pending_q.push_back(typed ? typed_s : s);
    endtask

    function automatic logic [31:0] gauss_draw();
        if ($urandom_range(0, 19) == 0) return $urandom;
        return $urandom_range(0, 6 << 20) - (3 << 20);
    endfunction

    // Register value for a phase: typical values most of the time, extremes
    // and raw words when the phase is an extreme one.
    function automatic logic [31:0] pick(bit wild, logic [31:0] typical);
        if (!wild) return typical;
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        sample_t ts;
        bit wild, pole;
        logic [31:0] bnd, ld;
        int plen;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_STEP_SIZE;
        cfg_data = 0;
        in_valid = 0;
        operation = OPC_ATTEMPT;
        load_value = 0;
        gauss_heun = 0;
        gauss_fallback = 0;
        uniform_draw = 0;
        out_stall = 0;
        stall_left = 0;
        errors = 0;
        n_results = 0;
        n_retry = 0;
        n_hard = 0;
        n_items = 0;
        no_gap = 0;
        no_stall = 0;
        m_step = 10486;
        m_sqrt = 104858;
        m_itau = 1048576;
        m_shape = 0;
        m_bound = 0;
        m_bounded = 0;
        m_decay = 1038142;
        m_gain = 104336;
        m_level = 0;
        m_work = 0;
        m_fails = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed table.
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].go_bounded) begin
                drain();
                write_reg(CFG_BOUND, 0);
                write_reg(CFG_BOUNDED, 1);
                cfg_we <= 0;
            end
            ts = '{dir_rows[i].exp_value, dir_rows[i].exp_outc};
            repeat (dir_rows[i].reps)
                send(dir_rows[i].op, dir_rows[i].ld, dir_rows[i].gh, dir_rows[i].gf,
                     dir_rows[i].u, dir_rows[i].typed, ts);
        end

        // Random phases, each with a fresh setting of every register. The
        // drain before each setting also makes the sender wait for all
        // outstanding results.
        while (n_items < 1530)
        begin
            drain();
            wild = ($urandom_range(0, 3) == 0);
            pole = ($urandom_range(0, 7) == 0);
            bnd = $urandom_range(1 << 19, 4 << 20);
            write_reg(CFG_STEP_SIZE, pick(wild, $urandom_range(1000, 60000)));
            write_reg(CFG_SQRT_STEP, pick(wild, $urandom_range(30000, 250000)));
            write_reg(CFG_INV_TAU, pick(wild, $urandom_range(1 << 18, 3 << 20)));
            write_reg(CFG_SHAPE_COEF, pole ? -(1 << 20)
                      : pick(wild, $urandom_range(0, 1 << 21) - (1 << 20)));
            write_reg(CFG_BOUND, pick(wild, bnd));
            write_reg(CFG_BOUNDED, 32'($urandom_range(0, 3) != 0));
            write_reg(CFG_OU_DECAY, pick(wild, $urandom_range(900000, 1048576)));
            write_reg(CFG_OU_GAIN, pick(wild, $urandom_range(50000, 300000)));
            cfg_we <= 0;
            no_gap = ($urandom_range(0, 3) == 0);
            no_stall = ($urandom_range(0, 3) == 0);
            plen = $urandom_range(40, 120);
            repeat (plen)
            begin
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0: ld = $urandom;
                        1: ld = pole ? (($urandom_range(0, 1)) ? (1 << 20) : -(1 << 20))
                                     : $urandom_range(0, bnd);
                        default: ld = $urandom_range(0, 2 * bnd) - bnd;
                    endcase
                    send(OPC_LOAD, ld, $urandom, $urandom, 20'($urandom_range(0, 20'hfffff)),
                         0, ts);
                end else begin
                    send(OPC_ATTEMPT, $urandom, gauss_draw(), gauss_draw(),
                         20'($urandom_range(0, 20'hfffff)), 0, ts);
                end
            end
        end

        drain();
        $display("Sent %0d items and checked %0d results, %0d after retries and %0d hard resets.",
                 n_items, n_results, n_retry, n_hard);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
